>>> src/pprgba_pkg.sv
// Shared types and constants for the PNG pixel to RGBA converter.
`default_nettype none

package pprgba_pkg;

    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int ENTRY_W           = 32;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 16;
    localparam int COUNT_W           = 9;

    typedef enum logic [2:0] {
        MODE_GRAY       = 3'd0,
        MODE_RGB        = 3'd2,
        MODE_PALETTE    = 3'd3,
        MODE_GRAY_ALPHA = 3'd4,
        MODE_RGBA       = 3'd6
    } color_mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COLOR_MODE    = 3'd0,
        CFG_KEY_ENABLE    = 3'd1,
        CFG_KEY_RED       = 3'd2,
        CFG_KEY_GREEN     = 3'd3,
        CFG_KEY_BLUE      = 3'd4,
        CFG_PALETTE_COUNT = 3'd5,
        CFG_ALPHA_COUNT   = 3'd6
    } cfg_index_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_LOAD  = 1'b1
    } operation_t;

    localparam logic [2:0] COLOR_MODE_RESET = 3'd6;
    localparam logic [7:0] ALPHA_OPAQUE     = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR      = 8'h00;

endpackage

`default_nettype wire

>>> src/png_pixel_to_rgba_core.sv
// PNG pixel to RGBA8 converter top level with palette memory and output register.
//
// The input stream carries one word per item. A load word (s_tuser high) writes one
// palette entry when its index is below the depth and yields no result; a pixel word
// (s_tuser low) yields one RGBA8 result on the output stream, with s_tlast copied to m_tlast.
// Configuration registers are written over the cfg channel, which is always ready,
// and must only be written while no pixel is in flight.
// From acceptance, a pixel passes the palette memory read stage and then the output
// register before m_tvalid rises. The block accepts one word per cycle as long
// as the receiver keeps m_tready high; the single-port-read palette memory sets that.
// When the receiver stalls, the output register and the memory read stage fill and
// s_tready drops; nothing is lost or repeated. Loads may follow pixels directly and
// a pixel may read an entry loaded in the previous cycle.
// Reset clears the valid bits, the sticky image failure flag and the configuration registers to
// their defaults (color mode 6, everything else 0). The palette memory is not
// cleared; reading an entry that was never loaded gives an undefined color.
// The sticky failure flag clears after the pixel marked with s_tlast.
`default_nettype none

module png_pixel_to_rgba_core #(
    parameter int PALETTE_DEPTH = pprgba_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // sample_0, sample_1, sample_2, sample_3, entry_index, entry_red, entry_green,
    // entry_blue, entry_alpha
    input  wire logic [71:0]                        s_tdata,
    // operation
    input  wire logic [0:0]                         s_tuser,
    input  wire logic                               s_tlast,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [31:0]                             m_tdata,
    // index_error, image_failed
    output logic [1:0]                              m_tuser,
    output logic                                    m_tlast,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pprgba_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pprgba_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam logic [pprgba_pkg::COUNT_W-1:0] DEPTH_LIMIT =
        pprgba_pkg::COUNT_W'(PALETTE_DEPTH);

    logic [2:0]                       color_mode_reg;
    logic                             key_enable_reg;
    logic [15:0]                      key_red_reg;
    logic [15:0]                      key_green_reg;
    logic [15:0]                      key_blue_reg;
    logic [pprgba_pkg::COUNT_W-1:0]   palette_count_reg;
    logic [pprgba_pkg::COUNT_W-1:0]   alpha_count_reg;

    logic                             in_fire;
    logic                             in_load;
    logic                             in_pixel;
    logic [7:0]                       in_sample [4];
    logic [7:0]                       in_entry_index;
    logic [pprgba_pkg::ENTRY_W-1:0]   in_entry;
    logic                             load_in_range;

    logic                             s1_valid_reg;
    logic                             s1_valid_next;
    logic                             s1_last_reg;
    logic [7:0]                       s1_sample_reg [4];
    logic [pprgba_pkg::ENTRY_W-1:0]   palette_rdata;
    logic                             s1_advance;

    logic                             out_free;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [31:0]                      out_data_reg;
    logic [1:0]                       out_user_reg;
    logic                             out_last_reg;
    logic                             failed_reg;
    logic                             failed_next;

    logic [7:0]                       red;
    logic [7:0]                       green;
    logic [7:0]                       blue;
    logic [7:0]                       alpha;
    logic                             index_error;
    logic                             image_failed;
    logic [pprgba_pkg::COUNT_W-1:0]   s1_index_wide;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg    <= pprgba_pkg::COLOR_MODE_RESET;
            key_enable_reg    <= 1'b0;
            key_red_reg       <= '0;
            key_green_reg     <= '0;
            key_blue_reg      <= '0;
            palette_count_reg <= '0;
            alpha_count_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pprgba_pkg::CFG_COLOR_MODE:    color_mode_reg    <= cfg_data[2:0];
                pprgba_pkg::CFG_KEY_ENABLE:    key_enable_reg    <= cfg_data[0];
                pprgba_pkg::CFG_KEY_RED:       key_red_reg       <= cfg_data;
                pprgba_pkg::CFG_KEY_GREEN:     key_green_reg     <= cfg_data;
                pprgba_pkg::CFG_KEY_BLUE:      key_blue_reg      <= cfg_data;
                pprgba_pkg::CFG_PALETTE_COUNT:
                    palette_count_reg <= cfg_data[pprgba_pkg::COUNT_W-1:0];
                pprgba_pkg::CFG_ALPHA_COUNT:
                    alpha_count_reg   <= cfg_data[pprgba_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input decode.
    assign in_sample[0]   = s_tdata[7:0];
    assign in_sample[1]   = s_tdata[15:8];
    assign in_sample[2]   = s_tdata[23:16];
    assign in_sample[3]   = s_tdata[31:24];
    assign in_entry_index = s_tdata[39:32];
    assign in_entry       = {s_tdata[47:40], s_tdata[55:48], s_tdata[63:56], s_tdata[71:64]};

    assign out_free   = !out_valid_reg || m_tready;
    assign s1_advance = s1_valid_reg && out_free;
    assign s_tready   = !s1_valid_reg || out_free;
    assign in_fire    = s_tvalid && s_tready;
    assign in_load    = in_fire && (s_tuser[0] == pprgba_pkg::OP_LOAD);
    assign in_pixel   = in_fire && (s_tuser[0] == pprgba_pkg::OP_PIXEL);

    assign load_in_range = {1'b0, in_entry_index} < DEPTH_LIMIT;

    pprgba_ram #(
        .WIDTH (pprgba_pkg::ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (in_load && load_in_range),
        .waddr (in_entry_index[AW-1:0]),
        .wdata (in_entry),
        .re    (in_pixel),
        .raddr (in_sample[0][AW-1:0]),
        .rdata (palette_rdata)
    );

    // Memory read stage.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_tready)
        begin
            s1_valid_next = in_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_pixel)
        begin
            s1_last_reg   <= s_tlast;
            s1_sample_reg <= in_sample;
        end
    end

    // Color conversion.
    assign s1_index_wide = {1'b0, s1_sample_reg[0]};

    always_comb
    begin
        red         = '0;
        green       = '0;
        blue        = '0;
        alpha       = pprgba_pkg::ALPHA_OPAQUE;
        index_error = 1'b0;
        unique case (color_mode_reg)
            pprgba_pkg::MODE_GRAY:
            begin
                red   = s1_sample_reg[0];
                green = s1_sample_reg[0];
                blue  = s1_sample_reg[0];
                if (key_enable_reg && (key_red_reg == {8'h00, s1_sample_reg[0]}))
                begin
                    alpha = pprgba_pkg::ALPHA_CLEAR;
                end
            end
            pprgba_pkg::MODE_RGB:
            begin
                red   = s1_sample_reg[0];
                green = s1_sample_reg[1];
                blue  = s1_sample_reg[2];
                if (key_enable_reg
                    && (key_red_reg == {8'h00, s1_sample_reg[0]})
                    && (key_green_reg == {8'h00, s1_sample_reg[1]})
                    && (key_blue_reg == {8'h00, s1_sample_reg[2]}))
                begin
                    alpha = pprgba_pkg::ALPHA_CLEAR;
                end
            end
            pprgba_pkg::MODE_PALETTE:
            begin
                if ((s1_index_wide >= palette_count_reg) || (s1_index_wide >= DEPTH_LIMIT))
                begin
                    index_error = 1'b1;
                end
                else
                begin
                    red   = palette_rdata[31:24];
                    green = palette_rdata[23:16];
                    blue  = palette_rdata[15:8];
                    if (s1_index_wide < alpha_count_reg)
                    begin
                        alpha = palette_rdata[7:0];
                    end
                end
            end
            pprgba_pkg::MODE_GRAY_ALPHA:
            begin
                red   = s1_sample_reg[0];
                green = s1_sample_reg[0];
                blue  = s1_sample_reg[0];
                alpha = s1_sample_reg[1];
            end
            pprgba_pkg::MODE_RGBA:
            begin
                red   = s1_sample_reg[0];
                green = s1_sample_reg[1];
                blue  = s1_sample_reg[2];
                alpha = s1_sample_reg[3];
            end
            default:
            begin
            end
        endcase
    end

    assign image_failed = failed_reg || index_error;

    always_comb
    begin
        failed_next    = failed_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = s1_valid_reg;
        end
        if (s1_advance)
        begin
            failed_next = image_failed && !s1_last_reg;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            failed_reg    <= failed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_data_reg <= {alpha, blue, green, red};
            out_user_reg <= {image_failed, index_error};
            out_last_reg <= s1_last_reg;
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

    a_error_is_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tuser[1])
        else $error("index error without image failure");

    a_error_palette_only: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && index_error |-> color_mode_reg == pprgba_pkg::MODE_PALETTE)
        else $error("index error outside palette mode");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_load |=> !s1_valid_reg)
        else $error("load word entered the read stage");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_sample_reg[0]))
        else $error("read stage lost a stalled pixel");

    a_failed_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance && s1_last_reg |=> !failed_reg)
        else $error("failure flag not cleared after last pixel");

endmodule

`default_nettype wire

>>> src/pprgba_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
`default_nettype none

module pprgba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire
